// File: sv/two_stacks_shared_array_unit_defines.svh
// Assertion macros used by the two-stack unit's checker file.
// Self-contained; no other file is needed to use these macros.
`ifndef TWO_STACKS_SHARED_ARRAY_UNIT_DEFINES_SVH
`define TWO_STACKS_SHARED_ARRAY_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("two-stack unit check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("two-stack unit check failed");

`endif

// File: sv/tsa_pkg.sv
// Shared types for the two-stack unit: operation codes and the
// command and status groups between controller and datapath. No dependencies.
package tsa_pkg;

    // Operation codes carried by the mode field of an input item.
    typedef enum logic [1:0] {
        MODE_PUSH_ONE = 2'd0,
        MODE_PUSH_TWO = 2'd1,
        MODE_POP_ONE  = 2'd2,
        MODE_POP_TWO  = 2'd3
    } mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;      // an item is accepted this cycle
        logic load_top;  // memory read data is ready for the popped stack's top
        logic load_out;  // capture the result into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read; // the accepted pop needs the new top from memory
    } dp_status_t;

endpackage

// File: sv/tsa_ctrl.sv
// Controller state machine of the two-stack unit.
// Depends on tsa_pkg for the command and status types.
module tsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tsa_pkg::dp_status_t status,
    output tsa_pkg::dp_cmd_t    cmd
);
    import tsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = status.need_read ? S_READ : S_DONE;
                end
            end
            S_READ:
            begin
                cmd.load_top = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out | (out_valid_reg & ~out_ready);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/tsa_datapath.sv
// Datapath of the two-stack unit: stack counters, cached tops, the shared
// memory and the output register. Depends on tsa_pkg.
module tsa_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tsa_pkg::dp_cmd_t    cmd,
    output tsa_pkg::dp_status_t status,
    input  logic [1:0]          mode,
    input  logic signed [31:0]  push_value,
    output logic                accepted,
    output logic [4:0]          depth_one,
    output logic [4:0]          depth_two,
    output logic                top_one_valid,
    output logic signed [31:0]  top_one_value,
    output logic                top_two_valid,
    output logic signed [31:0]  top_two_value
);
    import tsa_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] DEPTH_M1   = CW'(DEPTH - 1);
    localparam logic [CW:0]   DEPTH_FULL = (CW + 1)'(DEPTH);

    logic [DATA_WIDTH-1:0] store_mem [DEPTH];

    logic [CW-1:0]         count_one_reg, count_one_next;
    logic [CW-1:0]         count_two_reg, count_two_next;
    logic [DATA_WIDTH-1:0] top_one_reg, top_one_next;
    logic [DATA_WIDTH-1:0] top_two_reg, top_two_next;
    logic                  accepted_reg, accepted_next;
    logic                  pop_two_reg, pop_two_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  out_accepted_reg;
    logic [4:0]            out_depth_one_reg, out_depth_two_reg;
    logic                  out_one_valid_reg, out_two_valid_reg;
    logic [31:0]           out_one_value_reg, out_two_value_reg;

    logic                  full;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] wdata;

    assign full  = ({1'b0, count_one_reg} + {1'b0, count_two_reg}) == DEPTH_FULL;
    assign wdata = DATA_WIDTH'($unsigned(push_value));

    always_comb
    begin
        count_one_next = count_one_reg;
        count_two_next = count_two_reg;
        top_one_next   = top_one_reg;
        top_two_next   = top_two_reg;
        accepted_next  = accepted_reg;
        pop_two_next   = pop_two_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        if (cmd.take)
        begin
            accepted_next = 1'b0;
            pop_two_next  = (mode_t'(mode) == MODE_POP_TWO);
            case (mode_t'(mode))
                MODE_PUSH_ONE:
                begin
                    if (!full)
                    begin
                        accepted_next  = 1'b1;
                        wr_en          = 1'b1;
                        wr_addr        = AW'(count_one_reg);
                        count_one_next = count_one_reg + CW'(1);
                        top_one_next   = wdata;
                    end
                end
                MODE_PUSH_TWO:
                begin
                    if (!full)
                    begin
                        accepted_next  = 1'b1;
                        wr_en          = 1'b1;
                        wr_addr        = AW'(DEPTH_M1 - count_two_reg);
                        count_two_next = count_two_reg + CW'(1);
                        top_two_next   = wdata;
                    end
                end
                MODE_POP_ONE:
                begin
                    if (count_one_reg != '0)
                    begin
                        accepted_next  = 1'b1;
                        count_one_next = count_one_reg - CW'(1);
                        // The entry below the old top becomes the new top.
                        if (count_one_reg > CW'(1))
                        begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(count_one_reg - CW'(2));
                        end
                    end
                end
                MODE_POP_TWO:
                begin
                    if (count_two_reg != '0)
                    begin
                        accepted_next  = 1'b1;
                        count_two_next = count_two_reg - CW'(1);
                        // The entry above the old top becomes the new top.
                        if (count_two_reg > CW'(1))
                        begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(DEPTH_M1 - count_two_reg + CW'(2));
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.load_top)
        begin
            if (pop_two_reg)
            begin
                top_two_next = rd_data_reg;
            end
            else
            begin
                top_one_next = rd_data_reg;
            end
        end
    end

    // The presented item is a pop that will expose an older entry; the
    // controller only looks at this when it takes the item.
    assign status.need_read =
        ((mode_t'(mode) == MODE_POP_ONE) && (count_one_reg > CW'(1))) ||
        ((mode_t'(mode) == MODE_POP_TWO) && (count_two_reg > CW'(1)));

    // Shared store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_one_reg <= '0;
            count_two_reg <= '0;
        end
        else
        begin
            count_one_reg <= count_one_next;
            count_two_reg <= count_two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_one_reg  <= top_one_next;
        top_two_reg  <= top_two_next;
        accepted_reg <= accepted_next;
        pop_two_reg  <= pop_two_next;
        if (cmd.load_out)
        begin
            out_accepted_reg  <= accepted_reg;
            out_depth_one_reg <= 5'(count_one_reg);
            out_depth_two_reg <= 5'(count_two_reg);
            out_one_valid_reg <= (count_one_reg != '0);
            out_two_valid_reg <= (count_two_reg != '0);
            out_one_value_reg <= (count_one_reg != '0) ? 32'(top_one_reg) : '0;
            out_two_value_reg <= (count_two_reg != '0) ? 32'(top_two_reg) : '0;
        end
    end

    assign accepted      = out_accepted_reg;
    assign depth_one     = out_depth_one_reg;
    assign depth_two     = out_depth_two_reg;
    assign top_one_valid = out_one_valid_reg;
    assign top_one_value = out_one_value_reg;
    assign top_two_valid = out_two_valid_reg;
    assign top_two_value = out_two_value_reg;

endmodule

// File: sv/two_stacks_shared_array_unit.sv
// Top level of the two-stack unit: two LIFO stacks in one shared memory.
// Instantiates tsa_ctrl and tsa_datapath; depends on tsa_pkg.
//
//   Channel  Handshake            Payload
//   -------  -------------------  -----------------------------------------
//   input    in_valid / in_ready  mode, push_value
//   output   out_valid/out_ready  accepted, depth_one, depth_two,
//                                 top_one_valid/value, top_two_valid/value
//
// A result is loaded into the output register from the done state once its
// item is accepted, after the read state for a pop that leaves its stack
// non-empty and reads the new top from memory. No new item is taken until that load.
// Reset (rst_n, asynchronous, active low) empties both stacks; the memory is
// not cleared. A new item is taken while the previous result is still held,
// and a finished result waits inside the unit while the output is stalled.
module two_stacks_shared_array_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic [4:0]         depth_one,
    output logic [4:0]         depth_two,
    output logic               top_one_valid,
    output logic signed [31:0] top_one_value,
    output logic               top_two_valid,
    output logic signed [31:0] top_two_value
);
    import tsa_pkg::*;

    // Commands flow from the controller to the datapath; the datapath tells
    // the controller whether the accepted pop has to fetch a new top.
    dp_cmd_t    cmd;
    dp_status_t status;

    tsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath keeps each stack's top in a register, so pushes never read
    // the memory and only a pop that exposes an older entry needs a read.
    tsa_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .mode          (mode),
        .push_value    (push_value),
        .accepted      (accepted),
        .depth_one     (depth_one),
        .depth_two     (depth_two),
        .top_one_valid (top_one_valid),
        .top_one_value (top_one_value),
        .top_two_valid (top_two_valid),
        .top_two_value (top_two_value)
    );

endmodule

// File: sv/tsa_checker.sv
// Port-level checks for the two-stack unit, bound to its top level.
// Depends on two_stacks_shared_array_unit_defines.svh for the assertion macros.
`include "two_stacks_shared_array_unit_defines.svh"

module tsa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               accepted,
    input logic [4:0]         depth_one,
    input logic [4:0]         depth_two,
    input logic               top_one_valid,
    input logic signed [31:0] top_one_value,
    input logic               top_two_valid,
    input logic signed [31:0] top_two_value
);

    logic [76:0] out_bundle;

    assign out_bundle = {accepted, depth_one, depth_two, top_one_valid, top_one_value,
                         top_two_valid, top_two_value};

    // A stalled result stays put until it is taken.
    `TSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bundle))

    // The unit works on one item at a time, so it is busy after taking one.
    `TSA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)

    // An empty stack reports a zero top.
    `TSA_ASSERT_NOW(a_one_zero, clk, rst_n, out_valid && !top_one_valid, top_one_value == 32'sd0)
    `TSA_ASSERT_NOW(a_two_zero, clk, rst_n, out_valid && !top_two_valid, top_two_value == 32'sd0)

endmodule

bind two_stacks_shared_array_unit tsa_checker u_tsa_checker (.*);
